### hw/rtl/rcbp_pkg.sv
// Shared types and constants for the reference-counted buffer pool.
// Used by rcbp_engine and refcounted_buffer_pool.
package rcbp_pkg;

  localparam int NUM_BUFFERS = 32;

  localparam int REF_W  = 8;
  localparam int SIZE_W = 32;
  localparam int GID_W  = 5;

  localparam logic [REF_W-1:0] REF_MAX = 8'd255;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_ADDREF  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OUT   = 2'd1;
  localparam logic [1:0] ST_BADID = 2'd2;
  localparam logic [1:0] ST_FREED = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        buffer_id;
    logic [SIZE_W-1:0] size_needed;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [GID_W-1:0]  granted_id;
    logic              resized;
    logic [SIZE_W-1:0] granted_size;
  } out_t;

endpackage

### hw/rtl/rcbp_free_stack.sv
// LIFO stack of freed buffer ids with its fill count.
// Depends on nothing beyond its parameter; instantiated by rcbp_engine.
module rcbp_free_stack #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  logic [((NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1)-1:0] push_id,
  input  logic                                   pop,
  output logic [((NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1)-1:0] top_id,
  output logic                                   empty,
  output logic                                   full
);

  localparam int IdW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CntW = $clog2(NUM_BUFFERS + 1);

  logic [IdW-1:0]  stack_r [NUM_BUFFERS];
  logic [CntW-1:0] depth_r;
  logic [CntW-1:0] depth_nxt;
  logic [CntW-1:0] top_idx;

  assign empty   = (depth_r == '0);
  assign full    = (depth_r == CntW'(NUM_BUFFERS));
  assign top_idx = depth_r - 1'b1;
  assign top_id  = stack_r[top_idx[IdW-1:0]];

  always_comb begin
    depth_nxt = depth_r;
    if (pop && !empty) begin
      depth_nxt = depth_r - 1'b1;
    end else if (push && !full) begin
      depth_nxt = depth_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop && !full) begin
      stack_r[depth_r[IdW-1:0]] <= push_id;
    end
  end

  a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CntW'(NUM_BUFFERS))
    else $error("free stack depth beyond pool size");

endmodule

### hw/rtl/rcbp_engine.sv
// Decision logic and tables for one pool request: reference counts, sizes, creation count.
// Depends on rcbp_pkg and instantiates rcbp_free_stack.
module rcbp_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  rcbp_pkg::in_t req,
  output rcbp_pkg::out_t res
);

  localparam int NUM_BUFFERS = rcbp_pkg::NUM_BUFFERS;
  localparam int IdW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CntW = $clog2(NUM_BUFFERS + 1);
  localparam int CmpW = (CntW > 8) ? CntW : 8;

  logic [rcbp_pkg::REF_W-1:0]  counts_r [NUM_BUFFERS];
  logic [rcbp_pkg::SIZE_W-1:0] sizes_r  [NUM_BUFFERS];
  logic [CntW-1:0]             created_r;
  logic [CntW-1:0]             created_nxt;

  logic                        stk_push;
  logic                        stk_pop;
  logic [IdW-1:0]              stk_top;
  logic                        stk_empty;
  logic                        stk_full;

  logic [IdW-1:0]              id_idx;
  logic                        id_ok;
  logic                        pool_full;
  logic [rcbp_pkg::REF_W-1:0]  cnt_rd;
  logic [rcbp_pkg::SIZE_W-1:0] size_old;
  logic [IdW-1:0]              slot;
  logic                        alloc_ok;
  logic [rcbp_pkg::SIZE_W-1:0] gsize;
  logic                        cnt_we;
  logic [IdW-1:0]              cnt_waddr;
  logic [rcbp_pkg::REF_W-1:0]  cnt_wdata;
  logic                        size_we;

  rcbp_free_stack #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_free_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (stk_push),
    .push_id(id_idx),
    .pop    (stk_pop),
    .top_id (stk_top),
    .empty  (stk_empty),
    .full   (stk_full)
  );

  assign id_idx    = req.buffer_id[IdW-1:0];
  assign id_ok     = (CmpW'(req.buffer_id) < CmpW'(created_r));
  assign pool_full = (created_r == CntW'(NUM_BUFFERS));
  assign cnt_rd    = counts_r[id_idx];
  assign size_old  = sizes_r[stk_top];

  always_comb begin
    res         = '0;
    stk_push    = 1'b0;
    stk_pop     = 1'b0;
    slot        = '0;
    alloc_ok    = 1'b0;
    gsize       = req.size_needed;
    cnt_we      = 1'b0;
    cnt_waddr   = id_idx;
    cnt_wdata   = cnt_rd;
    size_we     = 1'b0;
    created_nxt = created_r;
    if (req_valid) begin
      unique case (req.opcode) inside
        rcbp_pkg::OP_ALLOC: begin
          if (!stk_empty) begin
            slot     = stk_top;
            stk_pop  = 1'b1;
            alloc_ok = 1'b1;
            if (size_old < req.size_needed) begin
              size_we     = 1'b1;
              res.resized = 1'b1;
            end else begin
              gsize = size_old;
            end
          end else if (!pool_full) begin
            slot        = created_r[IdW-1:0];
            created_nxt = created_r + 1'b1;
            size_we     = 1'b1;
            alloc_ok    = 1'b1;
          end else begin
            res.status = rcbp_pkg::ST_OUT;
          end
          if (alloc_ok) begin
            cnt_we           = 1'b1;
            cnt_waddr        = slot;
            cnt_wdata        = rcbp_pkg::REF_W'(1);
            res.granted_id   = rcbp_pkg::GID_W'(slot);
            res.granted_size = gsize;
          end
        end
        rcbp_pkg::OP_ADDREF, rcbp_pkg::OP_RELEASE: begin
          if (!id_ok) begin
            res.status = rcbp_pkg::ST_BADID;
          end else if (req.opcode == rcbp_pkg::OP_ADDREF) begin
            if (cnt_rd != rcbp_pkg::REF_MAX) begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rd + 1'b1;
            end
          end else if (cnt_rd == '0) begin
            res.status = rcbp_pkg::ST_FREED;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd - 1'b1;
            if (cnt_rd == rcbp_pkg::REF_W'(1) && !stk_full) begin
              stk_push = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      created_r <= '0;
    end else begin
      created_r <= created_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counts_r[cnt_waddr] <= cnt_wdata;
    end
    if (size_we) begin
      sizes_r[slot] <= req.size_needed;
    end
  end

  a_no_push_with_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_push && stk_pop))
    else $error("free stack pushed and popped in one cycle");

  a_create_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(req_valid && req.opcode == rcbp_pkg::OP_ALLOC && stk_empty)
    |=> created_r == $past(created_r))
    else $error("buffer created while a freed id was available");

  a_out_only_when_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && res.status == rcbp_pkg::ST_OUT) |-> (pool_full && stk_empty))
    else $error("out of buffers reported with buffers available");

endmodule

### hw/rtl/refcounted_buffer_pool.sv
// Top level of the reference-counted buffer pool: request register, result register.
// Depends on rcbp_pkg and instantiates rcbp_engine.
// A request taken at one edge goes through the request register (req_r) and then the result
// register (out_r) to out_res, where it shows with out_valid high and is taken by the receiver.
// Throughput: one request per cycle; the receiver cannot stall, so busy is low after reset.
// Reset: synchronous, active low; busy is high until the first edge after release.
module refcounted_buffer_pool (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rcbp_pkg::in_t  in_req,
  output logic           out_valid,
  output rcbp_pkg::out_t out_res
);

  rcbp_pkg::in_t  req_r;
  logic           req_valid_r;
  rcbp_pkg::out_t res;
  rcbp_pkg::out_t out_r;
  logic           out_valid_r;
  logic           busy_r;
  logic           accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  rcbp_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid_r),
    .req      (req_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      req_valid_r <= accept;
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (req_valid_r) begin
      out_r <= res;
    end
  end

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid_r)
    else $error("accepted request produced no result");

endmodule
